/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the size-class allocator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) 1'b1 |-> (cond)) \
      else $error("assertion failed");
// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst, cond)
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* hdl/scba_pkg.sv */
// ----------------------------------------------------------------------------
// scba_pkg
// Types and fixed constants shared by the size-class allocator modules.
// ----------------------------------------------------------------------------
package scba_pkg;

   // Fixed field widths.
   localparam int ADDR_W   = 24;
   localparam int SIZE_W   = 24;
   localparam int STATUS_W = 3;
   localparam int CLASS_W  = 4;

   // Size classes run from 2^MIN_POW up to 2^(LIMIT_POW-1) bytes.
   localparam int MIN_POW   = 6;
   localparam int LIMIT_POW = 20;
   localparam int NUM_STEPS = LIMIT_POW - MIN_POW - 1;
   localparam logic [SIZE_W-1:0] MIN_BLOCK = SIZE_W'(1) << MIN_POW;
   localparam logic [SIZE_W-1:0] MAX_BLOCK = SIZE_W'(1) << (LIMIT_POW - 1);

   // Result status codes.
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK      = 3'd0,
      STATUS_ZERO    = 3'd1,
      STATUS_LARGE   = 3'd2,
      STATUS_FULL    = 3'd3,
      STATUS_IGNORED = 3'd4
   } status_type;

   // Source of the returned user address.
   typedef enum logic [1:0] {
      ADDR_NONE,
      ADDR_HIT,
      ADDR_BUMP
   } addr_sel_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic         latch;
      logic         scan;
      logic         wr_hit;
      logic         append;
      logic         respond;
      status_type   rsp_status;
      addr_sel_type addr_sel;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic kind;
      logic zero_size;
      logic too_large;
      logic low_addr;
      logic scan_hit;
      logic scan_end;
      logic found;
      logic hit_free;
      logic fits;
   } ctrl_stat_type;

endpackage

/* hdl/scba_ram.sv */
// ----------------------------------------------------------------------------
// scba_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module scba_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/scba_ctrl.sv */
// ----------------------------------------------------------------------------
// scba_ctrl
// Request sequencer: accepts a beat, runs the table scan, issues the update
// and the response.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module scba_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   output logic                    rsp_strobe,
   output scba_pkg::ctrl_cmd_type  cmd,
   input  scba_pkg::ctrl_stat_type stat
);

   import scba_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff, busy_in;
   logic      rsp_strobe_ff, rsp_strobe_in;

   // Next state and datapath commands.
   always_comb begin
      state_in       = state_ff;
      busy_in        = busy_ff;
      rsp_strobe_in  = 1'b0;
      cmd            = '0;
      cmd.rsp_status = STATUS_OK;
      cmd.addr_sel   = ADDR_NONE;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.latch = 1'b1;
               busy_in   = 1'b1;
               state_in  = ST_DECODE;
            end
         end
         ST_DECODE: begin
            // Early rejects skip the table scan.
            if (!stat.kind && stat.zero_size) begin
               cmd.respond    = 1'b1;
               cmd.rsp_status = STATUS_ZERO;
            end else if (!stat.kind && stat.too_large) begin
               cmd.respond    = 1'b1;
               cmd.rsp_status = STATUS_LARGE;
            end else if (stat.kind && stat.low_addr) begin
               cmd.respond    = 1'b1;
               cmd.rsp_status = STATUS_IGNORED;
            end else begin
               state_in = ST_SCAN;
            end
            if (cmd.respond) begin
               rsp_strobe_in = 1'b1;
               busy_in       = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.scan_hit || stat.scan_end) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            cmd.respond   = 1'b1;
            rsp_strobe_in = 1'b1;
            busy_in       = 1'b0;
            state_in      = ST_IDLE;
            if (!stat.kind) begin
               // Allocate: reuse a free chunk, else carve a new one, else report full.
               if (stat.found) begin
                  cmd.wr_hit   = 1'b1;
                  cmd.addr_sel = ADDR_HIT;
               end else if (stat.fits) begin
                  cmd.append   = 1'b1;
                  cmd.addr_sel = ADDR_BUMP;
               end else begin
                  cmd.rsp_status = STATUS_FULL;
               end
            end else begin
               // Free: mark the found chunk free; a missing or already free chunk is ignored.
               if (stat.found && !stat.hit_free) begin
                  cmd.wr_hit = 1'b1;
               end else begin
                  cmd.rsp_status = STATUS_IGNORED;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
            busy_in  = 1'b0;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         busy_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         busy_ff       <= busy_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   assign busy       = busy_ff;
   assign rsp_strobe = rsp_strobe_ff;

   // An accepted beat makes the block busy with no result pending.
   `ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy_ff, busy_ff && !rsp_strobe_ff)
   // Each item gives a single one-cycle result.
   `ASSERT_NEXT(a_strobe_single, clock, reset, rsp_strobe_ff, !rsp_strobe_ff)
   // A result is shown only once the block is ready again.
   `ASSERT_IMPLY(a_strobe_idle, clock, reset, rsp_strobe_ff, !busy_ff && state_ff == ST_IDLE)

endmodule

/* hdl/scba_datapath.sv */
// ----------------------------------------------------------------------------
// scba_datapath
// Request registers, size-class decode, chunk table with scan logic, bump
// allocator and result registers.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module scba_datapath #(
   parameter int MAX_CHUNKS   = 256,
   parameter int HEAP_BYTES   = 16777216,
   parameter int HEADER_BYTES = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  scba_pkg::ctrl_cmd_type                 cmd,
   output scba_pkg::ctrl_stat_type                stat,
   input  logic                                   req_kind,
   input  logic [scba_pkg::SIZE_W-1:0]            req_size,
   input  logic [scba_pkg::ADDR_W-1:0]            req_address,
   output logic [scba_pkg::STATUS_W-1:0]          rsp_status,
   output logic [scba_pkg::ADDR_W-1:0]            rsp_address_res,
   output logic                                   rsp_reused
);

   import scba_pkg::*;

   localparam int IDX_W   = $clog2(MAX_CHUNKS);
   localparam int CNT_W   = $clog2(MAX_CHUNKS + 1);
   localparam int OFF_W   = $clog2(HEAP_BYTES + 1);
   localparam int START_W = $clog2(HEAP_BYTES);
   localparam int WORD_W  = START_W + CLASS_W + 1;
   localparam int EXT_W   = ((OFF_W > ADDR_W) ? OFF_W : ADDR_W) + 1;

   localparam logic [EXT_W-1:0] HDR_EXT  = EXT_W'(HEADER_BYTES);
   localparam logic [EXT_W-1:0] HEAP_EXT = EXT_W'(HEAP_BYTES);

   // Request registers.
   logic                kind_ff;
   logic [ADDR_W-1:0]   addr_ff;
   logic [CLASS_W-1:0]  cls_ff;
   logic                zero_ff, large_ff, low_ff;

   // Scan state.
   logic [CNT_W-1:0]    scan_ff;
   logic                pend_vld_ff;
   logic [IDX_W-1:0]    pend_idx_ff;
   logic                found_ff;
   logic [IDX_W-1:0]    hit_idx_ff;
   logic [WORD_W-1:0]   hit_word_ff;

   // Allocator state.
   logic [CNT_W-1:0]    count_ff;
   logic [OFF_W-1:0]    bump_ff;

   // Result registers.
   status_type          rsp_status_ff;
   logic [ADDR_W-1:0]   rsp_address_ff;
   logic                rsp_reused_ff;

   logic [NUM_STEPS-1:0] thermo;
   logic [CLASS_W-1:0]   cls_in;
   logic                 issue;
   logic                 scan_hit;
   logic [WORD_W-1:0]    rd_data;
   logic [START_W-1:0]   rd_start, hit_start;
   logic [CLASS_W-1:0]   rd_cls, hit_cls;
   logic                 rd_free;
   logic [EXT_W-1:0]     target;
   logic [EXT_W-1:0]     class_bytes;
   logic [EXT_W-1:0]     bump_end;
   logic                 fits;
   logic [EXT_W-1:0]     hit_user, bump_user;
   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   logic [WORD_W-1:0]    wr_data;

   // Size class: count the class boundaries that the size lies above.
   always_comb begin
      for (int k = 0; k < NUM_STEPS; k++) begin
         thermo[k] = req_size > (MIN_BLOCK << k);
      end
      cls_in = CLASS_W'($countones(thermo));
   end

   // Table word fields.
   assign rd_start  = rd_data[WORD_W-1 -: START_W];
   assign rd_cls    = rd_data[1 +: CLASS_W];
   assign rd_free   = rd_data[0];
   assign hit_start = hit_word_ff[WORD_W-1 -: START_W];
   assign hit_cls   = hit_word_ff[1 +: CLASS_W];

   // Scan compare on the entry returned from the table.
   assign target   = EXT_W'(addr_ff) - HDR_EXT;
   assign issue    = scan_ff < count_ff;
   assign scan_hit = pend_vld_ff &&
                     (kind_ff ? (EXT_W'(rd_start) == target)
                              : (rd_free && (rd_cls == cls_ff)));

   // Room check for a new chunk.
   assign class_bytes = EXT_W'(MIN_BLOCK) << cls_ff;
   assign bump_end    = EXT_W'(bump_ff) + class_bytes + HDR_EXT;
   assign fits        = (count_ff < CNT_W'(MAX_CHUNKS)) && (bump_end <= HEAP_EXT);

   // User addresses lie just past the header.
   assign hit_user  = EXT_W'(hit_start) + HDR_EXT;
   assign bump_user = EXT_W'(bump_ff) + HDR_EXT;

   // Table writes: reuse or free updates the hit entry, append adds one.
   assign wr_en   = cmd.wr_hit || cmd.append;
   assign wr_addr = cmd.append ? count_ff[IDX_W-1:0] : hit_idx_ff;
   assign wr_data = cmd.append ? {bump_ff[START_W-1:0], cls_ff, 1'b0}
                               : {hit_start, hit_cls, kind_ff};

   scba_ram #(
      .WIDTH (WORD_W),
      .DEPTH (MAX_CHUNKS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.scan && issue),
      .rd_addr (scan_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   // Request capture, scan hit capture and result payload.
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         kind_ff  <= req_kind;
         addr_ff  <= req_address;
         cls_ff   <= cls_in;
         zero_ff  <= (req_size == '0);
         large_ff <= (req_size > MAX_BLOCK);
         low_ff   <= (req_address < ADDR_W'(HEADER_BYTES));
      end
      if (cmd.scan && scan_hit) begin
         hit_idx_ff  <= pend_idx_ff;
         hit_word_ff <= rd_data;
      end
      if (cmd.scan) begin
         pend_idx_ff <= scan_ff[IDX_W-1:0];
      end
      if (cmd.respond) begin
         rsp_status_ff <= cmd.rsp_status;
         rsp_reused_ff <= (cmd.addr_sel == ADDR_HIT);
         case (cmd.addr_sel)
            ADDR_HIT:  rsp_address_ff <= hit_user[ADDR_W-1:0];
            ADDR_BUMP: rsp_address_ff <= bump_user[ADDR_W-1:0];
            default:   rsp_address_ff <= '0;
         endcase
      end
   end

   // Scan control and allocator state.
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff     <= '0;
         pend_vld_ff <= 1'b0;
         found_ff    <= 1'b0;
         count_ff    <= '0;
         bump_ff     <= '0;
      end else begin
         if (cmd.latch) begin
            scan_ff     <= '0;
            pend_vld_ff <= 1'b0;
            found_ff    <= 1'b0;
         end else if (cmd.scan) begin
            pend_vld_ff <= issue;
            if (issue) begin
               scan_ff <= scan_ff + CNT_W'(1);
            end
            if (scan_hit) begin
               found_ff <= 1'b1;
            end
         end
         if (cmd.append) begin
            count_ff <= count_ff + CNT_W'(1);
            bump_ff  <= bump_end[OFF_W-1:0];
         end
      end
   end

   // Status back to the controller.
   always_comb begin
      stat           = '0;
      stat.kind      = kind_ff;
      stat.zero_size = zero_ff;
      stat.too_large = large_ff;
      stat.low_addr  = low_ff;
      stat.scan_hit  = scan_hit;
      stat.scan_end  = !issue && !pend_vld_ff;
      stat.found     = found_ff;
      stat.hit_free  = hit_word_ff[0];
      stat.fits      = fits;
   end

   assign rsp_status      = rsp_status_ff;
   assign rsp_address_res = rsp_address_ff;
   assign rsp_reused      = rsp_reused_ff;

   // The chunk count never passes the table depth.
   `ASSERT_ALWAYS(a_count_range, clock, reset, count_ff <= CNT_W'(MAX_CHUNKS))
   // The bump offset never passes the end of the heap.
   `ASSERT_ALWAYS(a_bump_range, clock, reset, EXT_W'(bump_ff) <= HEAP_EXT)
   // An append adds exactly one chunk.
   `ASSERT_NEXT(a_append_count, clock, reset, cmd.append, count_ff == $past(count_ff) + CNT_W'(1))

endmodule

/* hdl/size_class_block_allocator.sv */
// ----------------------------------------------------------------------------
// size_class_block_allocator
// Power-of-two size-class allocator over a fixed heap and chunk table.
// Allocations reuse the earliest-created free chunk of their class or carve
// a new chunk behind a header; frees mark a chunk free by its user address.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake           Payload
//   request   start / busy        req_kind, req_size, req_address
//   response  rsp_strobe          rsp_status, rsp_address_res, rsp_reused
//
// A beat is taken when start is high and busy is low. Rejects that need no
// table lookup answer straight from the decode state; all other beats answer
// after the chunk table scan, which reads one entry per cycle through the
// single read port and stops early on a hit.
// Busy falls in the cycle that carries rsp_strobe, so the next beat can be
// taken then. The response is held for one cycle and cannot be stalled.
// Reset clears the chunk count and bump offset; no table clearing is needed.
// ----------------------------------------------------------------------------
module size_class_block_allocator #(
   parameter int MAX_CHUNKS   = 256,
   parameter int HEAP_BYTES   = 16777216,
   parameter int HEADER_BYTES = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_kind,
   input  logic [scba_pkg::SIZE_W-1:0]   req_size,
   input  logic [scba_pkg::ADDR_W-1:0]   req_address,
   output logic                          rsp_strobe,
   output logic [scba_pkg::STATUS_W-1:0] rsp_status,
   output logic [scba_pkg::ADDR_W-1:0]   rsp_address_res,
   output logic                          rsp_reused
);

   import scba_pkg::*;

   ctrl_cmd_type  cmd;
   ctrl_stat_type stat;

   // Sequencer.
   scba_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd),
      .stat       (stat)
   );

   // Table, bump allocator and result registers.
   scba_datapath #(
      .MAX_CHUNKS   (MAX_CHUNKS),
      .HEAP_BYTES   (HEAP_BYTES),
      .HEADER_BYTES (HEADER_BYTES)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_kind        (req_kind),
      .req_size        (req_size),
      .req_address     (req_address),
      .rsp_status      (rsp_status),
      .rsp_address_res (rsp_address_res),
      .rsp_reused      (rsp_reused)
   );

endmodule
